// File: design/mf3_pkg.sv
// Package with constants, types and sorting functions for the 3x3 median filter.
`default_nettype none
package mf3_pkg;
    localparam int MaxWidth = 4096;
    localparam int AddrW = $clog2(MaxWidth);
    localparam int CfgW = 13;
    localparam int RowW = 13;
    localparam int CoordW = 12;
    localparam logic [CfgW-1:0] WidthReset = CfgW'(640);
    localparam logic [CfgW-1:0] HeightReset = CfgW'(480);

    typedef enum logic {
        REG_FRAME_WIDTH = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    typedef logic [7:0] pix_t;

    // One vertical triple: top, middle, bottom.
    typedef struct packed {
        pix_t t;
        pix_t m;
        pix_t b;
    } triple_t;

    // Position flags of one pixel, settled when it is accepted.
    typedef struct packed {
        logic             first_col;
        logic             last_col;
        logic             first_row;
        logic             row_ge2;
        logic             last_row;
        logic [AddrW-1:0] col;
        logic [RowW-1:0]  row;
    } pos_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic pix_t mid3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(max2(a, b), c), min2(a, b));
    endfunction

    function automatic pix_t median9(input triple_t l, input triple_t m, input triple_t r);
        pix_t lo_l, lo_m, lo_r, hi_l, hi_m, hi_r, md_l, md_m, md_r;
        lo_l = min2(min2(l.t, l.m), l.b);
        lo_m = min2(min2(m.t, m.m), m.b);
        lo_r = min2(min2(r.t, r.m), r.b);
        hi_l = max2(max2(l.t, l.m), l.b);
        hi_m = max2(max2(m.t, m.m), m.b);
        hi_r = max2(max2(r.t, r.m), r.b);
        md_l = mid3(l.t, l.m, l.b);
        md_m = mid3(m.t, m.m, m.b);
        md_r = mid3(r.t, r.m, r.b);
        return mid3(min2(min2(hi_l, hi_m), hi_r), max2(max2(lo_l, lo_m), lo_r),
                    mid3(md_l, md_m, md_r));
    endfunction
endpackage
`default_nettype wire

// File: design/mf3_stream_if.sv
// Valid/ready channels for input pixels and median results.
`default_nettype none
interface mf3_pix_if;
    logic           valid;
    logic           ready;
    mf3_pkg::pix_t  pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface mf3_med_if;
    logic                             valid;
    logic                             ready;
    mf3_pkg::pix_t                    median;
    logic [mf3_pkg::CoordW-1:0]       out_col;
    logic [mf3_pkg::CoordW-1:0]       out_row;
    logic                             last_of_run;
    modport source (output valid, output median, output out_col, output out_row,
                    output last_of_run, input ready);
    modport sink (input valid, input median, input out_col, input out_row,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// File: design/mf3_line_store.sv
// Two line stores with registered reads and forwarding of the delayed older-row write.
`default_nettype none
module mf3_line_store (
    input  wire logic                        clk,
    input  wire logic                        rd_en,
    input  wire logic [mf3_pkg::AddrW-1:0]   rd_addr,
    input  wire mf3_pkg::pix_t               newer_wdata,
    input  wire logic                        older_we,
    input  wire logic [mf3_pkg::AddrW-1:0]   older_waddr,
    input  wire mf3_pkg::pix_t               older_wdata,
    output mf3_pkg::pix_t                    newer_rdata,
    output mf3_pkg::pix_t                    older_rdata
);
    mf3_pkg::pix_t newer_mem [mf3_pkg::MaxWidth];
    mf3_pkg::pix_t older_mem [mf3_pkg::MaxWidth];
    mf3_pkg::pix_t newer_rd_reg;
    mf3_pkg::pix_t older_rd_reg;
    logic          hit_reg;
    mf3_pkg::pix_t hit_data_reg;

    // Newer row: read old contents and write the new pixel at the same address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            newer_rd_reg <= newer_mem[rd_addr];
            newer_mem[rd_addr] <= newer_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            older_rd_reg <= older_mem[rd_addr];
        if (older_we)
            older_mem[older_waddr] <= older_wdata;
    end

    // Catch a read that races a write to the same older-row entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            hit_reg <= older_we && (older_waddr == rd_addr);
            hit_data_reg <= older_wdata;
        end
    end

    assign newer_rdata = newer_rd_reg;
    assign older_rdata = hit_reg ? hit_data_reg : older_rd_reg;
endmodule
`default_nettype wire

// File: design/median3x3_filter_edge_clamped.sv
// Top level of the edge-clamped 3x3 median filter.
//  channel  | dir | payload
//  pixels   | in  | pixel
//  medians  | out | median, out_col, out_row, last_of_run
//  config   | in  | write_en, reg_index, write_data
// One pixel is taken per cycle unless the result unit is busy; it passes stage 1, then the window.
// A pixel causes zero to four results; the unit sends one per cycle while medians is ready,
// so input stalls at row end and on the last row.
// Reset clears counters, valid flags and the window; line stores are not cleared.
// Back-pressure on medians holds the output and pending results; an idle result unit still loads.
`default_nettype none
module median3x3_filter_edge_clamped (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    mf3_pix_if.sink                           pixels,
    mf3_med_if.source                         medians,
    input  wire logic                         write_en,
    input  wire mf3_pkg::reg_index_t          reg_index,
    input  wire logic [mf3_pkg::CfgW-1:0]     write_data
);
    logic [mf3_pkg::CfgW-1:0]  width_reg, height_reg;
    logic [mf3_pkg::CfgW-1:0]  w_eff, h_eff;
    logic [mf3_pkg::AddrW-1:0] col_reg;
    logic [mf3_pkg::RowW-1:0]  row_reg;
    mf3_pkg::pos_t             pos_in;

    logic                      s1_valid_reg;
    mf3_pkg::pos_t             s1_pos_reg;
    mf3_pkg::pix_t             s1_pix_reg;
    mf3_pkg::pix_t             newer_rdata, older_rdata;
    mf3_pkg::triple_t          s1_triple;

    mf3_pkg::triple_t          win_reg [3];
    mf3_pkg::pos_t             e_pos_reg;
    logic [3:0]                pend_reg, pend_next;
    logic [3:0]                pick;
    logic                      out_free, emit, e_load, s1_adv, accept;
    mf3_pkg::triple_t          sel_l, sel_m, sel_r;
    logic                      sel_lower, sel_edge;

    logic                      out_valid_reg;
    mf3_pkg::pix_t             out_med_reg;
    logic [mf3_pkg::CoordW-1:0] out_col_reg, out_row_reg;
    logic                      out_last_reg;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
            w_eff = mf3_pkg::CfgW'(1);
        else if (width_reg > mf3_pkg::CfgW'(mf3_pkg::MaxWidth))
            w_eff = mf3_pkg::CfgW'(mf3_pkg::MaxWidth);
        h_eff = (height_reg == '0) ? mf3_pkg::CfgW'(1) : height_reg;
    end

    assign accept = pixels.valid && pixels.ready;

    always_comb
    begin
        pos_in.first_col = (col_reg == '0);
        pos_in.last_col = ({1'b0, col_reg} == w_eff - mf3_pkg::CfgW'(1));
        pos_in.first_row = (row_reg == '0);
        pos_in.row_ge2 = (row_reg >= mf3_pkg::RowW'(2));
        pos_in.last_row = (row_reg == h_eff - mf3_pkg::CfgW'(1));
        pos_in.col = col_reg;
        pos_in.row = row_reg;
    end

    // Configuration and position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= mf3_pkg::WidthReset;
            height_reg <= mf3_pkg::HeightReset;
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (write_en)
        begin
            case (reg_index)
                mf3_pkg::REG_FRAME_WIDTH:  width_reg <= write_data;
                mf3_pkg::REG_FRAME_HEIGHT: height_reg <= write_data;
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (pos_in.last_col)
            begin
                col_reg <= '0;
                row_reg <= pos_in.last_row ? '0 : row_reg + mf3_pkg::RowW'(1);
            end
            else
                col_reg <= col_reg + mf3_pkg::AddrW'(1);
        end
    end

    mf3_line_store u_line_store (
        .clk         (clk),
        .rd_en       (accept),
        .rd_addr     (col_reg),
        .newer_wdata (pixels.pixel),
        .older_we    (s1_valid_reg && !s1_pos_reg.first_row),
        .older_waddr (s1_pos_reg.col),
        .older_wdata (s1_triple.m),
        .newer_rdata (newer_rdata),
        .older_rdata (older_rdata)
    );

    // Stage 1: line-store data arrives; form the vertical triple.
    always_comb
    begin
        s1_triple.b = s1_pix_reg;
        if (s1_pos_reg.first_row)
        begin
            s1_triple.m = s1_pix_reg;
            s1_triple.t = s1_pix_reg;
        end
        else
        begin
            s1_triple.m = newer_rdata;
            s1_triple.t = s1_pos_reg.row_ge2 ? older_rdata : newer_rdata;
        end
    end

    assign s1_adv = s1_valid_reg && e_load;
    assign pixels.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pixels.ready)
            s1_valid_reg <= pixels.valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= pos_in;
            s1_pix_reg <= pixels.pixel;
        end
    end

    // Result unit: window plus a mask of pending results, sent lowest first.
    assign out_free = !out_valid_reg || medians.ready;
    assign pick = pend_reg & (~pend_reg + 4'd1);
    assign emit = (pend_reg != '0) && out_free;
    assign pend_next = emit ? (pend_reg & ~pick) : pend_reg;
    assign e_load = (pend_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            for (int k = 0; k < 3; k++)
                win_reg[k] <= '0;
        end
        else if (s1_adv)
        begin
            pend_reg <= {s1_pos_reg.last_row && s1_pos_reg.last_col,
                         s1_pos_reg.last_row && !s1_pos_reg.first_col,
                         !s1_pos_reg.first_row && s1_pos_reg.last_col,
                         !s1_pos_reg.first_row && !s1_pos_reg.first_col};
            if (s1_pos_reg.first_col)
            begin
                for (int k = 0; k < 3; k++)
                    win_reg[k] <= s1_triple;
            end
            else
            begin
                win_reg[0] <= win_reg[1];
                win_reg[1] <= win_reg[2];
                win_reg[2] <= s1_triple;
            end
        end
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            e_pos_reg <= s1_pos_reg;
    end

    // Lower-row results drop the top and repeat the bottom; edge results repeat the right column.
    assign sel_lower = pick[2] || pick[3];
    assign sel_edge = pick[1] || pick[3];

    function automatic mf3_pkg::triple_t lowered(input mf3_pkg::triple_t x, input logic en);
        mf3_pkg::triple_t y;
        y = x;
        if (en)
        begin
            y.t = x.m;
            y.m = x.b;
        end
        return y;
    endfunction

    always_comb
    begin
        sel_l = lowered(sel_edge ? win_reg[1] : win_reg[0], sel_lower);
        sel_m = lowered(sel_edge ? win_reg[2] : win_reg[1], sel_lower);
        sel_r = lowered(win_reg[2], sel_lower);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_med_reg <= mf3_pkg::median9(sel_l, sel_m, sel_r);
            out_col_reg <= sel_edge ? e_pos_reg.col : e_pos_reg.col - mf3_pkg::AddrW'(1);
            out_row_reg <= sel_lower ? e_pos_reg.row[mf3_pkg::CoordW-1:0]
                                     : mf3_pkg::CoordW'(e_pos_reg.row - mf3_pkg::RowW'(1));
            out_last_reg <= (pend_next == '0);
        end
    end

    assign medians.valid = out_valid_reg;
    assign medians.median = out_med_reg;
    assign medians.out_col = out_col_reg;
    assign medians.out_row = out_row_reg;
    assign medians.last_of_run = out_last_reg;

`ifndef NO_ASSERTIONS
    a_no_load_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |-> (pend_next == '0))
        else $error("new window loaded with results still pending");
    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pick))
        else $error("more than one result picked");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (medians.valid && !medians.ready) |=> medians.valid && $stable(medians.median))
        else $error("stalled result changed");
    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < w_eff) || $past(write_en))
        else $error("column counter ran past frame width");
`endif
endmodule
`default_nettype wire
